// ===== rtl/html_entity_unescape_strip_tags_assert.svh =====
// Assertion macros for the port-level checker of the entity unescape block.
`ifndef HTML_ENTITY_UNESCAPE_STRIP_TAGS_ASSERT_SVH
`define HTML_ENTITY_UNESCAPE_STRIP_TAGS_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst
`define HEUST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define HEUST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/heust_pkg.sv =====
// Package: item types, entity tables and character codes for the entity unescape block.
package heust_pkg;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;

  localparam int NUM_ENT     = 4;
  localparam int MAX_LETTERS = 4;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Entity names, [entity][letter]: nbsp, lt, gt, amp
  localparam logic [NUM_ENT-1:0][MAX_LETTERS-1:0][7:0] ENT_NAME = {
    {8'h00, 8'h70, 8'h6D, 8'h61},   // amp
    {8'h00, 8'h00, 8'h74, 8'h67},   // gt
    {8'h00, 8'h00, 8'h74, 8'h6C},   // lt
    {8'h70, 8'h73, 8'h62, 8'h6E}    // nbsp
  };
  localparam logic [NUM_ENT-1:0][2:0] ENT_LEN  = {3'd3, 3'd2, 3'd2, 3'd4};
  localparam logic [NUM_ENT-1:0][7:0] ENT_REPL = {CH_AMP, CH_GT, CH_LT, CH_SPACE};

  // Parser mode
  typedef enum logic [2:0] {
    MODE_TEXT = 3'b001,
    MODE_TAG  = 3'b010,
    MODE_ENT  = 3'b100
  } mode_t;

  // Channel items
  typedef struct packed {
    logic [7:0] text_byte;
    logic       ends_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       string_done;
  } out_item_t;

  // One classified item: optional '&'+letters flush, then optional tail result
  typedef struct packed {
    logic                        flush;
    logic [2:0]                  nlet;
    logic [MAX_LETTERS-1:0][7:0] letters;
    logic                        has_tail;
    logic [7:0]                  tail_byte;
    logic                        tail_valid;
    logic                        done;
  } job_t;

  // Queue write side seen by the front end
  typedef struct packed {
    logic push;
    job_t job;
  } qwr_t;

endpackage

// ===== rtl/heust_front.sv =====
// Front end: accepts text items, tracks tag/entity parsing, classifies into jobs.
module heust_front import heust_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     text_valid,
  output logic     text_stall,
  input  in_item_t text_item,
  input  logic     q_full,
  output qwr_t     qwr
);

  mode_t                       mode, mode_next;
  logic [2:0]                  count, count_next;
  logic [NUM_ENT-1:0]          alive, alive_next;
  logic [MAX_LETTERS-1:0][7:0] letters;
  logic                        let_we;
  logic                        accept;
  logic [7:0]                  b;
  logic [NUM_ENT-1:0]          still;
  logic                        done_hit;
  logic [1:0]                  done_idx;

  assign text_stall = q_full;
  assign accept     = text_valid && !q_full;
  assign b          = text_item.text_byte;

  // Entity match against every live name at the current letter position
  always_comb begin
    still    = '0;
    done_hit = 1'b0;
    done_idx = '0;
    for (int i = 0; i < NUM_ENT; i++) begin
      if (alive[i]) begin
        if (count < ENT_LEN[i]) begin
          if (ENT_NAME[i][count[1:0]] == b) still[i] = 1'b1;
        end else if (count == ENT_LEN[i] && b == CH_SEMI) begin
          done_hit = 1'b1;
          done_idx = 2'(i);
        end
      end
    end
  end

  // Next state and job build
  always_comb begin
    mode_next          = mode;
    count_next         = count;
    alive_next         = alive;
    let_we             = 1'b0;
    qwr.push           = 1'b0;
    qwr.job.flush      = 1'b0;
    qwr.job.nlet       = count;
    qwr.job.letters    = letters;
    qwr.job.has_tail   = 1'b0;
    qwr.job.tail_byte  = b;
    qwr.job.tail_valid = 1'b1;
    qwr.job.done       = 1'b0;
    if (accept) begin
      if (text_item.ends_string) begin
        qwr.job.flush      = (mode == MODE_ENT);
        qwr.job.has_tail   = 1'b1;
        qwr.job.tail_byte  = '0;
        qwr.job.tail_valid = 1'b0;
        qwr.job.done       = 1'b1;
        qwr.push           = 1'b1;
        mode_next          = MODE_TEXT;
        count_next         = '0;
        alive_next         = '1;
      end else begin
        case (mode)
          MODE_TAG: begin
            if (b == CH_GT) mode_next = MODE_TEXT;
          end
          MODE_ENT: begin
            if (done_hit) begin
              qwr.job.has_tail  = 1'b1;
              qwr.job.tail_byte = ENT_REPL[done_idx];
              qwr.push          = 1'b1;
              mode_next         = MODE_TEXT;
              count_next        = '0;
              alive_next        = '1;
            end else if (still != '0 && !count[2]) begin
              let_we     = 1'b1;
              count_next = 3'(count + 3'd1);
              alive_next = still;
            end else begin
              // mismatch: flush held prefix, then the byte as fresh text
              qwr.job.flush = 1'b1;
              qwr.push      = 1'b1;
              count_next    = '0;
              alive_next    = '1;
              if (b == CH_AMP) begin
                mode_next = MODE_ENT;
              end else if (b == CH_LT) begin
                mode_next = MODE_TAG;
              end else begin
                mode_next        = MODE_TEXT;
                qwr.job.has_tail = 1'b1;
              end
            end
          end
          default: begin
            if (b == CH_AMP) begin
              mode_next  = MODE_ENT;
              count_next = '0;
              alive_next = '1;
            end else if (b == CH_LT) begin
              mode_next = MODE_TAG;
            end else begin
              mode_next        = MODE_TEXT;
              qwr.job.has_tail = 1'b1;
              qwr.push         = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_TEXT;
      count <= '0;
      alive <= '1;
    end else begin
      mode  <= mode_next;
      count <= count_next;
      alive <= alive_next;
    end
  end

  // Held letters, only read below the count
  always_ff @(posedge clk) begin
    if (let_we) letters[count[1:0]] <= b;
  end

endmodule

// ===== rtl/heust_queue.sv =====
// Job queue between the front end and the emitter.
module heust_queue import heust_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  qwr_t qwr,
  output logic full,
  output logic rd_valid,
  input  logic rd_take,
  output job_t rd_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;
  logic          do_wr, do_rd;

  assign full     = (fill == CW'(DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_job   = mem[rd_ptr];
  assign do_wr    = qwr.push && !full;
  assign do_rd    = rd_take && rd_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= qwr.job;
  end

  // Pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr + 1'b1);
      if (do_rd) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr + 1'b1);
      if (do_wr && !do_rd)      fill <= CW'(fill + 1'b1);
      else if (do_rd && !do_wr) fill <= CW'(fill - 1'b1);
    end
  end

endmodule

// ===== rtl/heust_back.sv =====
// Emitter: walks each job's results into the output register, one per cycle unless res_stall holds it.
module heust_back import heust_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  output logic      job_take,
  input  job_t      job,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_item
);

  logic [2:0] pos;
  logic [2:0] total;
  logic [2:0] lidx;
  logic       load, last;
  out_item_t  cur;

  // Result count of this job: optional '&'+letters, optional tail
  assign total = 3'((job.flush ? 3'(job.nlet + 3'd1) : 3'd0) + {2'b0, job.has_tail});
  assign last  = (pos == 3'(total - 3'd1));
  assign load  = job_valid && (!res_valid || !res_stall);
  assign job_take = load && last;
  assign lidx  = 3'(pos - 3'd1);

  // Current result
  always_comb begin
    cur.last_of_run = last;
    cur.string_done = job.done;
    cur.byte_valid  = 1'b1;
    if (job.flush && pos == 3'd0) begin
      cur.out_byte = CH_AMP;
    end else if (job.flush && pos <= job.nlet) begin
      cur.out_byte = job.letters[lidx[1:0]];
    end else begin
      cur.out_byte   = job.tail_byte;
      cur.byte_valid = job.tail_valid;
    end
  end

  // Position within the job
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (load) begin
      pos <= last ? 3'd0 : 3'(pos + 3'd1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_item <= cur;
  end

endmodule

// ===== rtl/html_entity_unescape_strip_tags.sv =====
// Top level of the HTML entity unescape and tag strip block.
// Input channel text_valid/text_stall/text_item: one byte of an HTML string per
// item, or an end-of-string item (ends_string set, text_byte ignored).
// Output channel res_valid/res_stall/res_item: visible text, one byte per item.
// Tags '<'..'>' are dropped; &nbsp; &lt; &gt; &amp; become ' ' '<' '>' '&'.
// A broken entity gives '&' and its held letters, then the breaking byte is
// parsed afresh. An end item flushes any partial entity and finishes with a
// bare end marker (byte_valid low); last_of_run flags the final result of
// each input item.
// Path: jobs are registered in the job queue, results in the output register.
// Throughput: one input item per cycle while each gives at most one result;
// an item may give up to six results, which leave one at a time through
// the single output register. The job queue (QUEUE_DEPTH entries) absorbs
// such bursts; text_stall rises only when it is full.
// Reset: synchronous rst returns the parser to text mode and empties the queue.
// res_stall holds the output register; the queue then fills and stalls input.
module html_entity_unescape_strip_tags import heust_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      text_valid,
  output logic      text_stall,
  input  in_item_t  text_item,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_item
);

  qwr_t qwr;
  logic q_full, q_valid, q_take;
  job_t q_job;

  heust_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_item  (text_item),
    .q_full     (q_full),
    .qwr        (qwr)
  );

  heust_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .qwr      (qwr),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_take  (q_take),
    .rd_job   (q_job)
  );

  heust_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_take  (q_take),
    .job       (q_job),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule

// ===== rtl/heust_checker.sv =====
// Port-level checker for the entity unescape block, with its bind.
`include "html_entity_unescape_strip_tags_assert.svh"

module heust_checker import heust_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      text_valid,
  input logic      text_stall,
  input in_item_t  text_item,
  input logic      res_valid,
  input logic      res_stall,
  input out_item_t res_item
);

  // A bare end marker always closes its run and marks the string end
  `HEUST_ASSERT_NOW(a_marker_closes, res_valid && !res_item.byte_valid, res_item.string_done && res_item.last_of_run, "bare end marker without done/last")

  // Nothing comes out straight after reset
  `HEUST_ASSERT_NOW(a_quiet_after_reset, $past(rst), !res_valid, "result right after reset")

  // A stalled result stays offered
  `HEUST_ASSERT_NEXT(a_hold_valid, res_valid && res_stall, res_valid, "result dropped while stalled")

  // A stalled result keeps its payload
  `HEUST_ASSERT_NEXT(a_hold_item, res_valid && res_stall, $stable(res_item), "result changed while stalled")

  // A stalled input item stays offered and unchanged
  `HEUST_ASSERT_NEXT(a_hold_input, text_valid && text_stall, text_valid && $stable(text_item), "input item changed while stalled")

endmodule

bind html_entity_unescape_strip_tags heust_checker u_heust_checker (
  .clk        (clk),
  .rst        (rst),
  .text_valid (text_valid),
  .text_stall (text_stall),
  .text_item  (text_item),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .res_item   (res_item)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the HTML entity unescape and tag strip block.
`timescale 1ns / 1ps

module tb_top;
  import heust_pkg::*;

  // Entity spellings, letter k of entity e at ENT_WORD[e][k]: nbsp, lt, gt, amp
  localparam logic [3:0][3:0][7:0] ENT_WORD = {
    {8'h00, "p", "m", "a"},
    {8'h00, 8'h00, "t", "g"},
    {8'h00, 8'h00, "t", "l"},
    {"p", "s", "b", "n"}
  };
  localparam logic [3:0][2:0] ENT_SIZE = {3'd3, 3'd2, 3'd2, 3'd4};
  localparam logic [3:0][7:0] ENT_OUT  = {CH_AMP, CH_GT, CH_LT, CH_SPACE};
  // Bytes that sit close to the entity and tag syntax
  localparam int NEAR_N = 13;
  localparam logic [NEAR_N*8-1:0] NEAR_BYTES = "nbsplgtam&;<>";
  localparam int HOLD_CYCLES = 150;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      text_valid = 1'b0;
  logic      text_stall;
  in_item_t  text_item = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  out_item_t res_item;

  in_item_t  byte_stream[$];
  out_item_t expected_text[$];
  out_item_t run_q[$];
  int        errors = 0;
  int        sent_n = 0;
  int        got_n = 0;
  int        hold_left = 0;
  bit        held_once = 0;

  // Parser state of the predictor
  mode_t      pmode = MODE_TEXT;
  logic [7:0] held[4];
  logic [2:0] held_n = '0;
  logic [3:0] alive = 4'hF;

  html_entity_unescape_strip_tags u_top (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_item  (text_item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  task automatic put(input logic [7:0] b, input logic v, input logic d);
    out_item_t r;
    r.out_byte    = b;
    r.byte_valid  = v;
    r.last_of_run = 1'b0;
    r.string_done = d;
    run_q.push_back(r);
  endtask

  task automatic parse_reset();
    pmode  = MODE_TEXT;
    held_n = '0;
    alive  = 4'hF;
  endtask

  // '&' and the letters held so far, back to text mode
  task automatic flush_held(input logic d);
    put(CH_AMP, 1'b1, d);
    for (int i = 0; i < held_n; i++) put(held[i], 1'b1, d);
    parse_reset();
  endtask

  task automatic plain_byte(input logic [7:0] b);
    if (b == CH_AMP) begin
      pmode  = MODE_ENT;
      held_n = '0;
      alive  = 4'hF;
    end else if (b == CH_LT) begin
      pmode = MODE_TAG;
    end else begin
      put(b, 1'b1, 1'b0);
    end
  endtask

  // Work out the results of one accepted item and queue them
  task automatic unescape_item(input in_item_t it);
    int         hit;
    logic [3:0] still;
    logic [2:0] k;
    out_item_t  tail;
    run_q.delete();
    if (it.ends_string) begin
      if (pmode == MODE_ENT) flush_held(1'b1);
      put(8'h00, 1'b0, 1'b1);
      parse_reset();
      for (int i = 0; i < 4; i++) held[i] = '0;
    end else if (pmode == MODE_TAG) begin
      if (it.text_byte == CH_GT) pmode = MODE_TEXT;
    end else if (pmode == MODE_ENT) begin
      k     = held_n;
      still = '0;
      hit   = -1;
      for (int i = 0; i < 4; i++) begin
        if (alive[i]) begin
          if (k < ENT_SIZE[i]) begin
            if (ENT_WORD[i][k[1:0]] == it.text_byte) still[i] = 1'b1;
          end else if (k == ENT_SIZE[i] && it.text_byte == CH_SEMI) begin
            hit = i;
          end
        end
      end
      if (hit >= 0) begin
        put(ENT_OUT[hit], 1'b1, 1'b0);
        parse_reset();
      end else if (still != '0 && k < 4) begin
        held[k[1:0]] = it.text_byte;
        held_n       = k + 3'd1;
        alive        = still;
      end else begin
        flush_held(1'b0);
        plain_byte(it.text_byte);
      end
    end else begin
      pmode = MODE_TEXT;
      plain_byte(it.text_byte);
    end
    if (run_q.size() > 0) begin
      tail = run_q.pop_back();
      tail.last_of_run = 1'b1;
      run_q.push_back(tail);
    end
    foreach (run_q[i]) expected_text.push_back(run_q[i]);
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
      parse_reset();
      for (int i = 0; i < 4; i++) held[i] = '0;
    end else begin
      if (text_valid && !text_stall) begin
        unescape_item(text_item);
        sent_n++;
      end
      if (text_valid && text_stall) begin
        // stalled: item held as it is
      end else if (byte_stream.size() != 0 &&
                   ((sent_n >= 120 && sent_n < 180) || $urandom_range(0, 99) >= 36)) begin
        text_valid <= 1'b1;
        text_item  <= byte_stream.pop_front();
      end else begin
        text_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        got_n++;
        if (expected_text.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got %p", $time, res_item);
        end else begin
          want = expected_text.pop_front();
          if (want.out_byte !== res_item.out_byte) begin
            errors++;
            $display("%0t: out_byte expected %02h got %02h", $time,
                     want.out_byte, res_item.out_byte);
          end
          if (want.byte_valid !== res_item.byte_valid) begin
            errors++;
            $display("%0t: byte_valid expected %b got %b", $time,
                     want.byte_valid, res_item.byte_valid);
          end
          if (want.last_of_run !== res_item.last_of_run) begin
            errors++;
            $display("%0t: last_of_run expected %b got %b", $time,
                     want.last_of_run, res_item.last_of_run);
          end
          if (want.string_done !== res_item.string_done) begin
            errors++;
            $display("%0t: string_done expected %b got %b", $time,
                     want.string_done, res_item.string_done);
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (!held_once && got_n >= 80) begin
        held_once = 1;
        hold_left = HOLD_CYCLES - 1;
        res_stall <= 1'b1;
      end else begin
        res_stall <= (got_n < 120 || got_n >= 180) && ($urandom_range(0, 99) < 36);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic queue_byte(input logic [7:0] b, input logic e);
    in_item_t it;
    it.text_byte   = b;
    it.ends_string = e;
    byte_stream.push_back(it);
  endtask

  initial begin
    string      s;
    int         pick;
    int         e;
    int         n;
    logic [7:0] brk;

    // Directed: every entity, byte extremes, end in a tag, end in an entity
    s = "&nbsp;&lt;&gt;&amp;";
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(CH_LT, 1'b0);
    queue_byte(8'hFF, 1'b1);
    s = "&am&";
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], 1'b0);
    queue_byte(8'h00, 1'b1);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // sender pauses until every result so far is back
    while (byte_stream.size() != 0 || text_valid || expected_text.size() != 0)
      @(negedge clk);

    // Random: well-formed entities and tags, plus noise and broken ones
    while (byte_stream.size() < 222) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        queue_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 55) begin
        e = $urandom_range(0, 3);
        queue_byte(CH_AMP, 1'b0);
        for (int k = 0; k < ENT_SIZE[e]; k++) queue_byte(ENT_WORD[e][k], 1'b0);
        queue_byte(CH_SEMI, 1'b0);
      end else if (pick < 70) begin
        // entity cut short or broken by some byte
        e = $urandom_range(0, 3);
        n = $urandom_range(0, ENT_SIZE[e]);
        queue_byte(CH_AMP, 1'b0);
        for (int k = 0; k < n; k++) queue_byte(ENT_WORD[e][k], 1'b0);
        case ($urandom_range(0, 4))
          0: brk = CH_AMP;
          1: brk = CH_LT;
          2: brk = CH_SEMI;
          default: brk = 8'($urandom_range(0, 255));
        endcase
        queue_byte(brk, $urandom_range(0, 4) == 0);
      end else if (pick < 85) begin
        queue_byte(CH_LT, 1'b0);
        n = $urandom_range(0, 4);
        for (int k = 0; k < n; k++) queue_byte(8'($urandom_range(0, 255)), 1'b0);
        queue_byte(CH_GT, 1'b0);
      end else if (pick < 95) begin
        n = $urandom_range(0, NEAR_N - 1);
        queue_byte(NEAR_BYTES[8*n +: 8], 1'b0);
      end else begin
        queue_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    end

    while (byte_stream.size() != 0 || text_valid || expected_text.size() != 0)
      @(negedge clk);
    // catch any stray result after the last one
    repeat (20) @(negedge clk);

    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
